@@ src/xorshift_chained_pixel_cipher_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chained xorshift pixel cipher
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT_CHAINED_PIXEL_CIPHER_UNIT_ASSERT_SVH
`define XORSHIFT_CHAINED_PIXEL_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication: cond holds, then prop holds at the same edge.
`define XCPC_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication: cond holds, then prop holds at the following edge.
`define XCPC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ src/xcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// xcpc_pkg
// Constants, register indexes and the xorshift32 step for the pixel cipher.
// ----------------------------------------------------------------------------
package xcpc_pkg;

  localparam int CountWidth = 24;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;
  localparam int GenW       = 32;
  localparam int PixW       = 24;
  localparam int ChanW      = 8;
  localparam int PcountW    = 25;

  localparam logic [CfgIdxW-1:0] RegSeed    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStart   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPcount  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDecrypt = 2'd3;

  localparam int ShiftA = 13;
  localparam int ShiftB = 17;
  localparam int ShiftC = 5;

  // One xorshift32 step.
  function automatic logic [GenW-1:0] xs32_step(input logic [GenW-1:0] x);
    logic [GenW-1:0] t;
    t = x ^ (x << ShiftA);
    t = t ^ (t >> ShiftB);
    t = t ^ (t << ShiftC);
    return t;
  endfunction

endpackage

@@ src/xorshift_chained_pixel_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// xorshift_chained_pixel_cipher_unit
// Chained XOR pixel cipher: each RGB pixel is xored with a xorshift32 word
// and with the previous ciphertext pixel (or the start value for pixel 0).
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                  | Handshake
//  ---------+------------------------------------------+-------------------
//  input    | red_i, green_i, blue_i                   | in_valid_i/in_ready_o
//  output   | out_red_o, out_green_o, out_blue_o, last_o | out_valid_o/out_ready_i
//  config   | cfg_idx_i, cfg_data_i                    | cfg_we_i (no wait)
//
// Sequence: for pixel 0 of an image the generator is reloaded from the seed, then
// advanced once per cycle in the jump state, pixel_count times (zero counts as one),
// before the combine state loads the output register. Every other pixel takes
// one generator step on acceptance, then the combine state.
// Reset clears the control state, the pixel index and the registers to their
// defaults (pixel_count 1). A stalled output holds the combine cycle until
// the output register frees; input is taken only when the sequencer is idle.
// ----------------------------------------------------------------------------
module xorshift_chained_pixel_cipher_unit
  import xcpc_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input pixel items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ChanW-1:0]    red_i,
  input  logic [ChanW-1:0]    green_i,
  input  logic [ChanW-1:0]    blue_i,
  // output pixel items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ChanW-1:0]    out_red_o,
  output logic [ChanW-1:0]    out_green_o,
  output logic [ChanW-1:0]    out_blue_o,
  output logic                last_o
);

  // Wide enough to hold either pixel_count or 2^COUNT_WIDTH.
  localparam int WideW = 34;

  typedef enum logic [1:0] {
    StIdle,
    StJump,
    StCalc
  } state_e;

  // Configuration registers.
  logic [GenW-1:0]    seed_q;
  logic [GenW-1:0]    start_q;
  logic [PcountW-1:0] pcount_q;
  logic               decrypt_q;

  // Sequencer and datapath.
  state_e                 state_q;
  logic [COUNT_WIDTH-1:0] idx_q;
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [GenW-1:0]        gen_q;
  logic [PixW-1:0]        pix_q;
  logic [PixW-1:0]        prev_q;
  logic                   out_valid_q;
  logic [PixW-1:0]        out_pix_q;
  logic                   out_last_q;

  logic [WideW-1:0]       pc_wide;
  logic [WideW-1:0]       max_wide;
  logic [WideW-1:0]       cm1_wide;
  logic [COUNT_WIDTH-1:0] cnt_m1;
  logic [PixW-1:0]        chain;
  logic [PixW-1:0]        res;
  logic                   is_last;
  logic                   in_acc;
  logic                   out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      start_q   <= '0;
      pcount_q  <= PcountW'(1);
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSeed:    seed_q    <= cfg_data_i;
        RegStart:   start_q   <= cfg_data_i;
        RegPcount:  pcount_q  <= cfg_data_i[PcountW-1:0];
        RegDecrypt: decrypt_q <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  // Effective count minus one: zero acts as one, clamp at 2^COUNT_WIDTH.
  always_comb begin
    pc_wide  = WideW'(pcount_q);
    max_wide = WideW'(1) << COUNT_WIDTH;
    if (pc_wide == '0) begin
      cm1_wide = '0;
    end else if (pc_wide > max_wide) begin
      cm1_wide = max_wide - WideW'(1);
    end else begin
      cm1_wide = pc_wide - WideW'(1);
    end
    cnt_m1 = cm1_wide[COUNT_WIDTH-1:0];
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Chain on the start value for pixel 0, else on the last ciphertext.
  assign chain   = (idx_q == '0) ? start_q[PixW-1:0] : prev_q;
  assign res     = pix_q ^ chain ^ gen_q[PixW-1:0];
  assign is_last = (idx_q >= cnt_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      rem_q       <= '0;
      gen_q       <= '0;
      pix_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // drop the output item once taken, unless the combine cycle reloads it
      if (out_valid_q && out_ready_i && (state_q != StCalc)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            pix_q <= {red_i, green_i, blue_i};
            if (idx_q == '0) begin
              // new image: reload the generator and run the skip
              gen_q   <= seed_q;
              rem_q   <= cnt_m1;
              state_q <= StJump;
            end else begin
              gen_q   <= xs32_step(gen_q);
              state_q <= StCalc;
            end
          end
        end
        StJump: begin
          // advance once per cycle, pixel_count steps in total
          gen_q <= xs32_step(gen_q);
          if (rem_q == '0) begin
            state_q <= StCalc;
          end else begin
            rem_q <= rem_q - COUNT_WIDTH'(1);
          end
        end
        StCalc: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= res;
            out_last_q  <= is_last;
            prev_q      <= decrypt_q ? pix_q : res;
            idx_q       <= is_last ? '0 : idx_q + COUNT_WIDTH'(1);
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_pix_q[23:16];
  assign out_green_o = out_pix_q[15:8];
  assign out_blue_o  = out_pix_q[7:0];
  assign last_o      = out_last_q;

endmodule

@@ src/xcpc_checker.sv @@
// ----------------------------------------------------------------------------
// xcpc_checker
// Port-level checks for the chained xorshift pixel cipher.
// ----------------------------------------------------------------------------
`include "xorshift_chained_pixel_cipher_unit_assert.svh"

module xcpc_checker
  import xcpc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [ChanW-1:0]    out_red_o,
  input logic [ChanW-1:0]    out_green_o,
  input logic [ChanW-1:0]    out_blue_o,
  input logic                last_o
);

  `XCPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o, "output item dropped while stalled")
  `XCPC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o)
                    && $stable(last_o), "output item changed while stalled")
  `XCPC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
                    !in_ready_o, "input taken while an item is in work")
  `XCPC_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o),
                   $past(!in_ready_o), "result appeared without an item in work")

endmodule

bind xorshift_chained_pixel_cipher_unit xcpc_checker u_xcpc_checker (.*);
